// ----- rtl/kwsm_pkg.sv -----
package kwsm_pkg;

    localparam int NUM_LISTS_DEF   = 8;
    localparam int LIST_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ID_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_LOADED = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_MERGED = 2'd2;
    localparam status_t ST_EMPTY  = 2'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [ID_W-1:0]          list_id;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] merged_value;
        logic [ID_W-1:0]          source_list;
    } out_t;

endpackage

// ----- rtl/kwsm_store.sv -----
module kwsm_store
    import kwsm_pkg::*;
#(
    parameter int ADDR_W = 9,
    parameter int WORD_W = VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [2**ADDR_W];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/k_way_sorted_merge.sv -----
// Channel   | Ports                        | Carries
// ----------+------------------------------+----------------------------------
// input     | s_valid, s_ready, s_data     | load or pull request (in_t)
// result    | m_valid, m_ready, m_data     | status, merged value, list (out_t)
// config    | cfg_wen, cfg_wdata           | active_lists, written at once
//
// A load request passes through the S_LOAD and S_OUT states before ready returns.
// In a pull request one shared comparator visits each active list head in turn,
// and each visit waits in S_SCAN_RD for the registered read of the list store
// before S_SCAN_CMP compares the head; the pull then goes through S_POP and S_OUT.
// Reset is synchronous and empties every list; the store itself is not cleared.
// A finished result waits in the output register while the next request is taken.
module k_way_sorted_merge
    import kwsm_pkg::*;
#(
    parameter int NUM_LISTS   = NUM_LISTS_DEF,
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    localparam int LIST_W = $clog2(NUM_LISTS);
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int N_W    = $clog2(NUM_LISTS + 1);
    localparam int ADDR_W = LIST_W + PTR_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_LOAD     = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CMP = 6'b001000,
        S_POP      = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    in_t                    item_reg, item_next;
    logic [CFG_W-1:0]       active_reg;
    logic [N_W-1:0]         n_reg, n_next;
    logic [LIST_W-1:0]      scan_reg, scan_next;
    logic                   found_reg, found_next;
    logic [LIST_W-1:0]      best_idx_reg, best_idx_next;
    logic [VALUE_WIDTH-1:0] best_val_reg, best_val_next;
    out_t                   res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    logic [PTR_W-1:0] rp_reg   [NUM_LISTS];
    logic [PTR_W-1:0] wp_reg   [NUM_LISTS];
    logic [CNT_W-1:0] fill_reg [NUM_LISTS];

    logic                   id_ok;
    logic [LIST_W-1:0]      lidx;
    logic [LIST_W-1:0]      sel_idx;
    logic [CNT_W-1:0]       sel_fill;
    logic [PTR_W-1:0]       sel_rp;
    logic [PTR_W-1:0]       sel_wp;
    logic [PTR_W-1:0]       rp_inc;
    logic [PTR_W-1:0]       wp_inc;
    logic                   load_ok;
    logic                   pop_ok;
    logic                   take;
    logic                   last;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    assign id_ok = (int'(item_reg.list_id) < NUM_LISTS);
    assign lidx  = LIST_W'(item_reg.list_id);

    always_comb begin
        case (state_reg)
            S_LOAD: begin
                sel_idx = lidx;
            end
            S_POP: begin
                sel_idx = best_idx_reg;
            end
            default: begin
                sel_idx = scan_reg;
            end
        endcase
    end

    assign sel_fill = fill_reg[sel_idx];
    assign sel_rp   = rp_reg[sel_idx];
    assign sel_wp   = wp_reg[sel_idx];
    assign rp_inc   = (sel_rp == PTR_W'(LIST_DEPTH - 1)) ? '0 : sel_rp + 1'b1;
    assign wp_inc   = (sel_wp == PTR_W'(LIST_DEPTH - 1)) ? '0 : sel_wp + 1'b1;

    assign load_ok = (state_reg == S_LOAD) && id_ok && (sel_fill != CNT_W'(LIST_DEPTH));
    assign pop_ok  = (state_reg == S_POP) && found_reg;

    assign mem_waddr = {lidx, sel_wp};
    assign mem_raddr = {scan_reg, sel_rp};
    assign mem_wdata = VALUE_WIDTH'(item_reg.value);

    assign take = (state_reg == S_SCAN_CMP) && (sel_fill != '0)
               && (!found_reg || ($signed(mem_rdata) < $signed(best_val_reg)));
    assign last = ((N_W'(scan_reg) + N_W'(1)) == n_reg);

    kwsm_store #(
        .ADDR_W (ADDR_W),
        .WORD_W (VALUE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_ok),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        n_next        = n_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    scan_next  = '0;
                    found_next = 1'b0;
                    if (int'(active_reg) > NUM_LISTS) begin
                        n_next = N_W'(NUM_LISTS);
                    end else begin
                        n_next = N_W'(active_reg);
                    end
                    if (s_data.mode == MODE_LOAD) begin
                        state_next = S_LOAD;
                    end else if (active_reg == '0) begin
                        state_next = S_POP;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_LOAD: begin
                res_next.status       = load_ok ? ST_LOADED : ST_FULL;
                res_next.merged_value = '0;
                res_next.source_list  = '0;
                state_next            = S_OUT;
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (take) begin
                    found_next    = 1'b1;
                    best_idx_next = scan_reg;
                    best_val_next = mem_rdata;
                end
                if (last) begin
                    state_next = S_POP;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_POP: begin
                if (found_reg) begin
                    res_next.status       = ST_MERGED;
                    res_next.merged_value = DATA_W'($signed(best_val_reg));
                    res_next.source_list  = ID_W'(best_idx_reg);
                end else begin
                    res_next.status       = ST_EMPTY;
                    res_next.merged_value = '0;
                    res_next.source_list  = '0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= ACTIVE_RESET;
            n_reg       <= '0;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            n_reg       <= n_next;
            scan_reg    <= scan_next;
            found_reg   <= found_next;
            if (cfg_wen) begin
                active_reg <= cfg_wdata;
            end
            if (load_ok) begin
                wp_reg[sel_idx]   <= wp_inc;
                fill_reg[sel_idx] <= sel_fill + 1'b1;
            end
            if (pop_ok) begin
                rp_reg[sel_idx]   <= rp_inc;
                fill_reg[sel_idx] <= sel_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sim/k_way_sorted_merge_tb.sv -----
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
    import kwsm_pkg::*;

    localparam int LISTS      = NUM_LISTS_DEF;
    localparam int DEPTH      = LIST_DEPTH_DEF;
    localparam int PULL_WAIT  = 2 * LISTS + 8;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_LIMIT = 3000;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_val;
        in_t              req;
        bit               typed;
        out_t             result;
    } merge_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wen   = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_t              s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_t             m_data;

    bit   drv_typed  = 1'b0;
    out_t drv_expect = '0;
    bit   hold_req   = 1'b0;
    bit   hold_seen  = 1'b0;
    int   hold_cnt   = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   step_max = 3;

    logic [CFG_W-1:0]          lanes_on = ACTIVE_RESET;
    logic signed [DATA_W-1:0]  lane_q [LISTS][$];
    logic signed [DATA_W-1:0]  last_val [LISTS];
    out_t                      merge_q [$];
    merge_row_t                plan_rows [$];

    k_way_sorted_merge u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t merge_predict(in_t d);
        out_t r;
        int   n;
        int   best;
        int   i;
        r = '0;
        if (d.mode == MODE_LOAD) begin
            if (d.list_id >= LISTS || lane_q[d.list_id].size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                lane_q[d.list_id].insert(lane_q[d.list_id].size(), d.value);
                r.status = ST_LOADED;
            end
        end else begin
            n = (lanes_on > LISTS) ? LISTS : int'(lanes_on);
            best = -1;
            for (i = 0; i < n; i++) begin
                if (lane_q[i].size() != 0) begin
                    if (best < 0 || lane_q[i][0] < lane_q[best][0]) begin
                        best = i;
                    end
                end
            end
            if (best < 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_MERGED;
                r.merged_value = lane_q[best].pop_front();
                r.source_list = best[ID_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] next_val(int l);
        longint t;
        t = longint'(last_val[l]) + longint'($urandom_range(step_max, 0));
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647;
        end
        last_val[l] = t[DATA_W-1:0];
        return last_val[l];
    endfunction

    function automatic merge_row_t req_row(logic mode, logic [ID_W-1:0] id,
                                           logic signed [DATA_W-1:0] v, bit typed,
                                           status_t st, logic signed [DATA_W-1:0] mv,
                                           logic [ID_W-1:0] src);
        merge_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_val = '0;
        row.req.mode = mode;
        row.req.list_id = id;
        row.req.value = v;
        row.typed = typed;
        row.result.status = st;
        row.result.merged_value = mv;
        row.result.source_list = src;
        return row;
    endfunction

    function automatic merge_row_t cfg_row(logic [CFG_W-1:0] v);
        merge_row_t row;
        row = req_row(MODE_LOAD, '0, '0, 1'b0, ST_LOADED, '0, '0);
        row.is_cfg = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic void add_row(merge_row_t row);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(in_t d, bit typed, out_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        drv_typed <= typed;
        drv_expect <= want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != items_sent) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_lanes(logic [CFG_W-1:0] v);
        wait_drain();
        repeat (PULL_WAIT) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        lanes_on = v;
    endtask

    task automatic run_phase(int count, int tx_pct, int rx_pct, logic [CFG_W-1:0] lanes,
                             bit fill, bit hold, bit pause);
        in_t d;
        int  n;
        int  l;
        int  r;
        logic signed [DATA_W-1:0] base;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        set_lanes(lanes);
        base = $urandom;
        step_max = $urandom_range(1) ? 3 : 100000;
        for (l = 0; l < LISTS; l++) begin
            last_val[l] = base;
        end
        n = 0;
        if (fill) begin
            l = $urandom_range(LISTS - 1);
            repeat (DEPTH + 2) begin
                d.mode = MODE_LOAD;
                d.list_id = ID_W'(l);
                d.value = next_val(l);
                send_request(d, 1'b0, '0);
                n++;
            end
        end
        while (n < count) begin
            if (hold && n == 20) begin
                hold_req <= ~hold_req;
            end
            if (pause && n == count / 2) begin
                wait_drain();
            end
            r = $urandom_range(99);
            d.mode = (r >= 50 && r < 90) ? MODE_PULL : MODE_LOAD;
            d.list_id = ID_W'($urandom_range(LISTS - 1));
            d.value = $urandom;
            if (r < 50) begin
                d.value = next_val(int'(d.list_id));
            end
            send_request(d, 1'b0, '0);
            n++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (merge_q.size() == 0) begin
                    report_mismatch("unexpected result", m_data.merged_value, '0);
                end else begin
                    want = merge_q.pop_front();
                    if (m_data.status !== want.status) begin
                        report_mismatch("status", m_data.status, want.status);
                    end
                    if (m_data.merged_value !== want.merged_value) begin
                        report_mismatch("merged_value", m_data.merged_value,
                                        want.merged_value);
                    end
                    if (m_data.source_list !== want.source_list) begin
                        report_mismatch("source_list", m_data.source_list,
                                        want.source_list);
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready) begin
                want = merge_predict(s_data);
                merge_q.insert(merge_q.size(), drv_typed ? drv_expect : want);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("k_way_sorted_merge test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        merge_row_t row;
        int         i;
        // Extremes and tie-breaking with all eight lists active.
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_EMPTY, 0, 0));
        add_row(req_row(MODE_LOAD, 0, VAL_MIN, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 7, VAL_MAX, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 3, 0, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 5, -1, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 1, VAL_MIN, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 6, -1, 1, ST_MERGED, VAL_MIN, 0));
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_MERGED, VAL_MIN, 1));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_MERGED, VAL_MAX, 7));
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_EMPTY, 0, 0));
        // With no active lists every pull is empty; inactive lists still load.
        add_row(cfg_row(4'd0));
        add_row(req_row(MODE_LOAD, 2, 5, 1, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_EMPTY, 0, 0));
        add_row(cfg_row(4'd1));
        add_row(req_row(MODE_PULL, 0, 0, 1, ST_EMPTY, 0, 0));
        add_row(req_row(MODE_LOAD, 0, 42, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));
        // An active count above the list count saturates.
        add_row(cfg_row(4'd15));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 4, 32'sh5a5a_a5a5, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_LOAD, 6, 32'sh5a5a_a5a5, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));
        add_row(req_row(MODE_PULL, 0, 0, 0, ST_LOADED, 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < plan_rows.size(); i++) begin
            row = plan_rows[i];
            if (row.is_cfg) begin
                set_lanes(row.cfg_val);
            end else begin
                send_request(row.req, row.typed, row.result);
            end
        end

        run_phase(130, 0, 0, 4'd8, 1'b1, 1'b0, 1'b0);
        run_phase(120, 79, 0, 4'd3, 1'b0, 1'b0, 1'b1);
        run_phase(120, 0, 79, 4'd15, 1'b1, 1'b0, 1'b0);
        run_phase(110, 38, 38, CFG_W'($urandom_range(7, 2)), 1'b0, 1'b0, 1'b0);
        run_phase(120, 0, 0, 4'd8, 1'b0, 1'b1, 1'b0);
        run_phase(40, 38, 38, 4'd0, 1'b0, 1'b0, 1'b0);
        run_phase(100, 38, 38, 4'd8, 1'b0, 1'b0, 1'b0);

        wait_drain();
        repeat (PULL_WAIT) @(posedge aclk);
        if (mismatches == 0 && merge_q.size() == 0) begin
            $display("k_way_sorted_merge test passed");
        end else begin
            $display("k_way_sorted_merge test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kwsm_pkg.sv
rtl/kwsm_store.sv
rtl/k_way_sorted_merge.sv
sim/k_way_sorted_merge_tb.sv
